@@ design/ecwe_pkg.sv @@
// Shared types, constants and helpers for the engine cycle window estimator.
`timescale 1ns / 1ps
`default_nettype none
package ecwe_pkg;

    localparam int RING_DEPTH = 64;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    localparam int DIV_N_W    = 64;
    localparam int DIV_D_W    = 48;
    localparam int DIV_C_W    = $clog2(DIV_N_W + 1);

    localparam int SD_W       = 38;
    localparam int SW_W       = 40;
    localparam int SA_W       = 27;
    localparam int ST_W       = 64;
    localparam int TERM_W     = 56;

    localparam logic [29:0]       RPM_NUM     = 30'd954929659;
    localparam logic [TERM_W-1:0] TERM_CAP    = TERM_W'(1) << 55;
    localparam logic [31:0]       WDUR_RESET  = 32'd1000000;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_NONMONO  = 3'd2;
    localparam logic [2:0] ST_ID_GAP   = 3'd3;
    localparam logic [2:0] ST_TIME_GAP = 3'd4;

    localparam logic [1:0] Q_NONE  = 2'd0;
    localparam logic [1:0] Q_WARM  = 2'd1;
    localparam logic [1:0] Q_READY = 2'd2;

    typedef struct packed {
        logic [31:0]        id;
        logic [31:0]        dur;
        logic [19:0]        ang;
        logic signed [31:0] work;
        logic [23:0]        rpm;
        logic [TERM_W-1:0]  term;
    } ring_entry_t;

    localparam int ENTRY_W = $bits(ring_entry_t);

    function automatic logic [23:0] sat_u24(input logic [DIV_N_W-1:0] v);
        sat_u24 = (v > DIV_N_W'(24'hFFFFFF)) ? 24'hFFFFFF : v[23:0];
    endfunction

    function automatic logic [23:0] sat_s24(input logic [DIV_N_W-1:0] mag, input logic neg);
        logic [23:0] r;
        if (neg) begin
            if (mag > DIV_N_W'(24'h800000)) r = 24'h800000;
            else r = ~mag[23:0] + 24'd1;
        end else begin
            if (mag > DIV_N_W'(24'h7FFFFF)) r = 24'h7FFFFF;
            else r = mag[23:0];
        end
        sat_s24 = r;
    endfunction

endpackage
`default_nettype wire

@@ design/ecwe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ecwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ design/ecwe_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ecwe_div
    import ecwe_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [DIV_N_W-1:0] num,
    input  wire logic [DIV_D_W-1:0] den,
    output logic                    done,
    output logic      [DIV_N_W-1:0] quo
);

    logic [DIV_N_W-1:0] q_reg, q_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_C_W-1:0] cnt_reg;
    logic               busy_reg, done_reg;
    logic [DIV_D_W:0]   trial, diff;
    logic               ge;

    always_comb begin
        trial    = {rem_reg, q_reg[DIV_N_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        q_next   = {q_reg[DIV_N_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg    <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= DIV_C_W'(DIV_N_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                q_reg   <= q_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - DIV_C_W'(1);
                if (cnt_reg == DIV_C_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule
`default_nettype wire

@@ design/engine_cycle_window_estimator.sv @@
// Top level: cycle checks, window ring, eviction, scan and window statistics.
//
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    s_tdata (cycle word), s_tuser (kind)
//  m_        out  m_tvalid / m_tready    m_tdata (result word)
//  cfg_      in   cfg_valid / cfg_ready  cfg_data (window duration, us)
//
// A cycle word's work grows with each evicted entry and each window entry
// scanned, and it makes six passes through the shared divider.
// A rejected word goes from the checks straight to the result; a break word yields no result.
// Reset is synchronous on aresetn low; the ring needs no clearing pass.
// s_tready is low while a word is in work; a finished word waits on a held result.
`timescale 1ns / 1ps
`default_nettype none
module engine_cycle_window_estimator
    import ecwe_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [0] sample_valid, [32:1] cycle_id, [80:33] start_time, [128:81] end_time,
    // [160:129] cycle_duration, [180:161] crank_angle, [212:181] brake_work
    input  wire logic [215:0] s_tdata,
    // [0] kind
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [2:0] status, [4:3] quality, [5] continuous, [6] capacity_limited,
    // [13:7] window_count, [45:14] last_cycle_id, [69:46] mean_rpm,
    // [93:70] mean_torque, [117:94] mean_power, [141:118] min_rpm,
    // [165:142] max_rpm, [205:166] torque_variance
    output logic [207:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_CAP_RD, S_CAP_EV, S_RPM_PREP, S_RPM_DIV, S_TQ_PREP, S_TQ_DIV,
        S_SQ, S_TERM, S_WRITE, S_EV_RD, S_EV_CHK, S_SCAN, S_MRPM_PREP, S_MRPM_DIV,
        S_MTQ_PREP, S_MTQ_DIV, S_SEC_PREP, S_SEC_DIV, S_VAR_MUL, S_VAR_SUB,
        S_MPWR_PREP, S_MPWR_DIV, S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SD_W-1:0]  sum_dur_reg, sum_dur_next;
    logic signed [SW_W-1:0] sum_work_reg, sum_work_next;
    logic [SA_W-1:0]  sum_ang_reg, sum_ang_next;
    logic [ST_W-1:0]  sum_term_reg, sum_term_next;
    logic             seen_id_reg, seen_id_next, seen_time_reg, seen_time_next;
    logic [31:0]      last_id_reg, last_id_next;
    logic [47:0]      last_end_reg, last_end_next;
    logic [31:0]      wdur_reg, wdur_next;

    logic             in_sv_reg, in_sv_next;
    logic [31:0]      in_id_reg, in_id_next;
    logic [47:0]      in_start_reg, in_start_next, in_end_reg, in_end_next;
    logic [31:0]      in_dur_reg, in_dur_next;
    logic [19:0]      in_ang_reg, in_ang_next;
    logic signed [31:0] in_work_reg, in_work_next;

    logic [CNT_W-1:0] k_reg, k_next;
    logic             pend_reg, pend_next;
    logic [23:0]      minr_reg, minr_next, maxr_reg, maxr_next;
    logic [2:0]       status_reg, status_next;
    logic             caplim_reg, caplim_next;
    logic [23:0]      e_rpm_reg, e_rpm_next, e_mag_reg, e_mag_next;
    logic [TERM_W-1:0] e_term_reg, e_term_next;
    logic [66:0]      mul_reg, mul_next;
    logic             big_reg, big_next;
    logic [23:0]      r_mrpm_reg, r_mrpm_next, r_mtq_reg, r_mtq_next, r_mpwr_reg, r_mpwr_next;
    logic [47:0]      r_amt_reg, r_amt_next;
    logic [DIV_N_W-1:0] r_sec_reg, r_sec_next;
    logic [39:0]      r_var_reg, r_var_next;

    logic [DIV_N_W-1:0] div_num_reg, div_num_next, div_quo;
    logic [DIV_D_W-1:0] div_den_reg, div_den_next;
    logic             div_go_reg, div_go_next, div_done;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [207:0]     m_tdata_reg, m_tdata_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    ring_entry_t      wr_entry, rd_entry;
    logic [ENTRY_W-1:0] ram_rdata;

    logic             do_remove, do_clear, accept;
    logic [CNT_W:0]   ins_sum, scan_sum;
    logic [IDX_W-1:0] ins_idx, scan_idx;
    logic [SW_W-1:0]  abs_w;
    logic [32:0]      abs_in_w;
    logic [47:0]      span;
    logic             inval;
    logic [66:0]      prod;
    logic [DIV_N_W-1:0] var_full;

    ecwe_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ecwe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go_reg),
        .num     (div_num_reg),
        .den     (div_den_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign rd_entry  = ring_entry_t'(ram_rdata);
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        ins_sum  = {1'b0, CNT_W'(head_reg)} + {1'b0, count_reg};
        if (ins_sum >= (CNT_W + 1)'(RING_DEPTH)) ins_sum = ins_sum - (CNT_W + 1)'(RING_DEPTH);
        ins_idx  = ins_sum[IDX_W-1:0];
        scan_sum = {1'b0, CNT_W'(head_reg)} + {1'b0, k_reg};
        if (scan_sum >= (CNT_W + 1)'(RING_DEPTH)) scan_sum = scan_sum - (CNT_W + 1)'(RING_DEPTH);
        scan_idx = scan_sum[IDX_W-1:0];
        abs_w    = sum_work_reg[SW_W-1] ? SW_W'(-sum_work_reg) : SW_W'(sum_work_reg);
        abs_in_w = in_work_reg[31] ? 33'(-34'(in_work_reg)) : 33'(in_work_reg);
        span     = in_end_reg - in_start_reg;
        inval    = !in_sv_reg || (in_dur_reg == 32'd0) || (in_ang_reg == 20'd0)
                   || (in_end_reg <= in_start_reg) || (span != 48'(in_dur_reg));
        prod     = 67'(mul_reg[46:0]) * 67'(in_ang_reg);
        var_full = (!big_reg && (r_sec_reg > mul_reg[63:0])) ? r_sec_reg - mul_reg[63:0] : '0;
    end

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        sum_dur_next   = sum_dur_reg;
        sum_work_next  = sum_work_reg;
        sum_ang_next   = sum_ang_reg;
        sum_term_next  = sum_term_reg;
        seen_id_next   = seen_id_reg;
        seen_time_next = seen_time_reg;
        last_id_next   = last_id_reg;
        last_end_next  = last_end_reg;
        wdur_next      = cfg_valid ? cfg_data : wdur_reg;
        in_sv_next     = in_sv_reg;
        in_id_next     = in_id_reg;
        in_start_next  = in_start_reg;
        in_end_next    = in_end_reg;
        in_dur_next    = in_dur_reg;
        in_ang_next    = in_ang_reg;
        in_work_next   = in_work_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        minr_next      = minr_reg;
        maxr_next      = maxr_reg;
        status_next    = status_reg;
        caplim_next    = caplim_reg;
        e_rpm_next     = e_rpm_reg;
        e_mag_next     = e_mag_reg;
        e_term_next    = e_term_reg;
        mul_next       = mul_reg;
        big_next       = big_reg;
        r_mrpm_next    = r_mrpm_reg;
        r_mtq_next     = r_mtq_reg;
        r_mpwr_next    = r_mpwr_reg;
        r_amt_next     = r_amt_reg;
        r_sec_next     = r_sec_reg;
        r_var_next     = r_var_reg;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        div_go_next    = 1'b0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        ram_we         = 1'b0;
        ram_waddr      = ins_idx;
        ram_raddr      = head_reg;
        wr_entry       = '{id: in_id_reg, dur: in_dur_reg, ang: in_ang_reg, work: in_work_reg,
                           rpm: e_rpm_reg, term: e_term_reg};
        do_remove      = 1'b0;
        do_clear       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    in_sv_next    = s_tdata[0];
                    in_id_next    = s_tdata[32:1];
                    in_start_next = s_tdata[80:33];
                    in_end_next   = s_tdata[128:81];
                    in_dur_next   = s_tdata[160:129];
                    in_ang_next   = s_tdata[180:161];
                    in_work_next  = s_tdata[212:181];
                    if (s_tuser[0]) begin
                        seen_id_next   = 1'b0;
                        seen_time_next = 1'b0;
                        do_clear       = 1'b1;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                caplim_next = 1'b0;
                state_next  = S_OUT;
                if (inval) begin
                    if (!seen_id_reg || in_id_reg > last_id_reg) begin
                        last_id_next = in_id_reg;
                        seen_id_next = 1'b1;
                    end
                    last_end_next  = in_end_reg;
                    seen_time_next = 1'b1;
                    status_next    = ST_INVALID;
                    do_clear       = 1'b1;
                end else if (seen_id_reg && in_id_reg <= last_id_reg) begin
                    status_next = ST_NONMONO;
                    do_clear    = 1'b1;
                end else if (seen_id_reg && in_id_reg != last_id_reg + 32'd1) begin
                    last_id_next   = in_id_reg;
                    last_end_next  = in_end_reg;
                    seen_time_next = 1'b1;
                    status_next    = ST_ID_GAP;
                    do_clear       = 1'b1;
                end else if (seen_time_reg && in_start_reg != last_end_reg) begin
                    last_id_next  = in_id_reg;
                    seen_id_next  = 1'b1;
                    last_end_next = in_end_reg;
                    status_next   = ST_TIME_GAP;
                    do_clear      = 1'b1;
                end else begin
                    last_id_next   = in_id_reg;
                    last_end_next  = in_end_reg;
                    seen_id_next   = 1'b1;
                    seen_time_next = 1'b1;
                    status_next    = ST_OK;
                    state_next     = (count_reg >= CNT_W'(RING_DEPTH)) ? S_CAP_RD : S_RPM_PREP;
                end
            end
            S_CAP_RD: begin
                state_next = S_CAP_EV;
            end
            S_CAP_EV: begin
                do_remove   = 1'b1;
                caplim_next = 1'b1;
                state_next  = S_RPM_PREP;
            end
            S_RPM_PREP: begin
                div_num_next = DIV_N_W'(in_ang_reg) * DIV_N_W'(RPM_NUM)
                               + DIV_N_W'(in_dur_reg) * DIV_N_W'(500);
                div_den_next = DIV_D_W'(in_dur_reg) * DIV_D_W'(1000);
                div_go_next  = 1'b1;
                state_next   = S_RPM_DIV;
            end
            S_RPM_DIV: begin
                if (div_done) begin
                    e_rpm_next = sat_u24(div_quo);
                    state_next = S_TQ_PREP;
                end
            end
            S_TQ_PREP: begin
                div_num_next = DIV_N_W'(abs_in_w) * DIV_N_W'(100) + DIV_N_W'(in_ang_reg[19:1]);
                div_den_next = DIV_D_W'(in_ang_reg);
                div_go_next  = 1'b1;
                state_next   = S_TQ_DIV;
            end
            S_TQ_DIV: begin
                if (div_done) begin
                    if (in_work_reg[31]) begin
                        e_mag_next = (div_quo > DIV_N_W'(24'h800000)) ? 24'h800000 : div_quo[23:0];
                    end else begin
                        e_mag_next = (div_quo > DIV_N_W'(24'h7FFFFF)) ? 24'h7FFFFF : div_quo[23:0];
                    end
                    state_next = S_SQ;
                end
            end
            S_SQ: begin
                mul_next   = 67'(48'(e_mag_reg) * 48'(e_mag_reg));
                state_next = S_TERM;
            end
            S_TERM: begin
                e_term_next = (prod > 67'(TERM_CAP)) ? TERM_CAP : prod[TERM_W-1:0];
                state_next  = S_WRITE;
            end
            S_WRITE: begin
                ram_we        = 1'b1;
                count_next    = count_reg + CNT_W'(1);
                sum_dur_next  = sum_dur_reg + SD_W'(in_dur_reg);
                sum_work_next = sum_work_reg + SW_W'(in_work_reg);
                sum_ang_next  = sum_ang_reg + SA_W'(in_ang_reg);
                sum_term_next = sum_term_reg + ST_W'(e_term_reg);
                state_next    = S_EV_RD;
            end
            S_EV_RD: begin
                if (count_reg > CNT_W'(1)) begin
                    state_next = S_EV_CHK;
                end else begin
                    k_next     = '0;
                    pend_next  = 1'b0;
                    minr_next  = 24'hFFFFFF;
                    maxr_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_EV_CHK: begin
                if (sum_dur_reg - SD_W'(rd_entry.dur) >= SD_W'(wdur_reg)) begin
                    do_remove  = 1'b1;
                    state_next = S_EV_RD;
                end else begin
                    k_next     = '0;
                    pend_next  = 1'b0;
                    minr_next  = 24'hFFFFFF;
                    maxr_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                ram_raddr = scan_idx;
                if (pend_reg) begin
                    if (rd_entry.rpm < minr_reg) minr_next = rd_entry.rpm;
                    if (rd_entry.rpm > maxr_reg) maxr_next = rd_entry.rpm;
                end
                if (k_reg < count_reg) begin
                    k_next    = k_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_MRPM_PREP;
                end
            end
            S_MRPM_PREP: begin
                div_num_next = DIV_N_W'(sum_ang_reg) * DIV_N_W'(RPM_NUM)
                               + DIV_N_W'(sum_dur_reg) * DIV_N_W'(500);
                div_den_next = DIV_D_W'(sum_dur_reg) * DIV_D_W'(1000);
                div_go_next  = 1'b1;
                state_next   = S_MRPM_DIV;
            end
            S_MRPM_DIV: begin
                if (div_done) begin
                    r_mrpm_next = sat_u24(div_quo);
                    state_next  = S_MTQ_PREP;
                end
            end
            S_MTQ_PREP: begin
                div_num_next = DIV_N_W'(abs_w) * DIV_N_W'(100) + DIV_N_W'(sum_ang_reg[SA_W-1:1]);
                div_den_next = DIV_D_W'(sum_ang_reg);
                div_go_next  = 1'b1;
                state_next   = S_MTQ_DIV;
            end
            S_MTQ_DIV: begin
                if (div_done) begin
                    r_amt_next = div_quo[47:0];
                    r_mtq_next = sat_s24(div_quo, sum_work_reg[SW_W-1]);
                    state_next = S_SEC_PREP;
                end
            end
            S_SEC_PREP: begin
                div_num_next = DIV_N_W'(sum_term_reg);
                div_den_next = DIV_D_W'(sum_ang_reg);
                div_go_next  = 1'b1;
                state_next   = S_SEC_DIV;
            end
            S_SEC_DIV: begin
                if (div_done) begin
                    r_sec_next = div_quo;
                    state_next = S_VAR_MUL;
                end
            end
            S_VAR_MUL: begin
                mul_next   = 67'(64'(r_amt_reg[31:0]) * 64'(r_amt_reg[31:0]));
                big_next   = (r_amt_reg[47:32] != 16'd0);
                state_next = S_VAR_SUB;
            end
            S_VAR_SUB: begin
                r_var_next = (var_full > DIV_N_W'(40'hFFFFFFFFFF)) ? 40'hFFFFFFFFFF
                                                                   : var_full[39:0];
                state_next = S_MPWR_PREP;
            end
            S_MPWR_PREP: begin
                div_num_next = DIV_N_W'(abs_w) * DIV_N_W'(1000) + DIV_N_W'(sum_dur_reg[SD_W-1:1]);
                div_den_next = DIV_D_W'(sum_dur_reg);
                div_go_next  = 1'b1;
                state_next   = S_MPWR_DIV;
            end
            S_MPWR_DIV: begin
                if (div_done) begin
                    r_mpwr_next = sat_s24(div_quo, sum_work_reg[SW_W-1]);
                    state_next  = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    if (status_reg == ST_OK) begin
                        m_tdata_next = {2'b00, r_var_reg, maxr_reg, minr_reg, r_mpwr_reg,
                                        r_mtq_reg, r_mrpm_reg, in_id_reg, count_reg,
                                        caplim_reg, 1'b1,
                                        (sum_dur_reg >= SD_W'(wdur_reg)) ? Q_READY : Q_WARM,
                                        status_reg};
                    end else begin
                        m_tdata_next = {205'd0, status_reg};
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (do_remove) begin
            sum_dur_next  = sum_dur_reg - SD_W'(rd_entry.dur);
            sum_work_next = sum_work_reg - SW_W'(rd_entry.work);
            sum_ang_next  = sum_ang_reg - SA_W'(rd_entry.ang);
            sum_term_next = sum_term_reg - ST_W'(rd_entry.term);
            head_next     = (head_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
            count_next    = count_reg - CNT_W'(1);
        end
        if (do_clear) begin
            head_next     = '0;
            count_next    = '0;
            sum_dur_next  = '0;
            sum_work_next = '0;
            sum_ang_next  = '0;
            sum_term_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            sum_dur_reg   <= '0;
            sum_work_reg  <= '0;
            sum_ang_reg   <= '0;
            sum_term_reg  <= '0;
            seen_id_reg   <= 1'b0;
            seen_time_reg <= 1'b0;
            last_id_reg   <= '0;
            last_end_reg  <= '0;
            wdur_reg      <= WDUR_RESET;
            pend_reg      <= 1'b0;
            div_go_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            sum_dur_reg   <= sum_dur_next;
            sum_work_reg  <= sum_work_next;
            sum_ang_reg   <= sum_ang_next;
            sum_term_reg  <= sum_term_next;
            seen_id_reg   <= seen_id_next;
            seen_time_reg <= seen_time_next;
            last_id_reg   <= last_id_next;
            last_end_reg  <= last_end_next;
            wdur_reg      <= wdur_next;
            pend_reg      <= pend_next;
            div_go_reg    <= div_go_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        in_sv_reg    <= in_sv_next;
        in_id_reg    <= in_id_next;
        in_start_reg <= in_start_next;
        in_end_reg   <= in_end_next;
        in_dur_reg   <= in_dur_next;
        in_ang_reg   <= in_ang_next;
        in_work_reg  <= in_work_next;
        k_reg        <= k_next;
        minr_reg     <= minr_next;
        maxr_reg     <= maxr_next;
        status_reg   <= status_next;
        caplim_reg   <= caplim_next;
        e_rpm_reg    <= e_rpm_next;
        e_mag_reg    <= e_mag_next;
        e_term_reg   <= e_term_next;
        mul_reg      <= mul_next;
        big_reg      <= big_next;
        r_mrpm_reg   <= r_mrpm_next;
        r_mtq_reg    <= r_mtq_next;
        r_mpwr_reg   <= r_mpwr_next;
        r_amt_reg    <= r_amt_next;
        r_sec_reg    <= r_sec_next;
        r_var_reg    <= r_var_next;
        div_num_reg  <= div_num_next;
        div_den_reg  <= div_den_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule
`default_nettype wire
